@@ rtl/core/lpom_pkg.sv @@
// ----------------------------------------------------------------------------
// lpom_pkg
// Shared types, widths and the CORDIC arctangent table for the landmark pose
// observation model.
// ----------------------------------------------------------------------------
package lpom_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_COUNT   = 24;
    localparam int STEPS_USED   = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS;

    localparam int POS_W   = 32;
    localparam int ANG_W   = 16;
    localparam int TRIG_W  = 16;
    localparam int DIFF_W  = POS_W + 1;
    localparam int XY_W    = 34;
    localparam int Z_W     = 33;
    localparam int PROD_W  = DIFF_W + TRIG_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int TRIG_FRAC = 14;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
    localparam logic signed [16:0] QUARTER = 17'sd16384;
    localparam logic signed [16:0] HALF    = 17'sd32768;

    typedef struct packed {
        logic signed [POS_W-1:0] robot_x;
        logic signed [POS_W-1:0] robot_y;
        logic        [ANG_W-1:0] robot_heading;
        logic signed [POS_W-1:0] mark_x;
        logic signed [POS_W-1:0] mark_y;
        logic        [ANG_W-1:0] mark_heading;
        logic signed [POS_W-1:0] seen_x;
        logic signed [POS_W-1:0] seen_y;
        logic        [ANG_W-1:0] seen_heading;
    } t_pose_word;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [POS_W-1:0]  sx;
        logic signed [POS_W-1:0]  sy;
        logic signed [POS_W-1:0]  rx;
        logic signed [POS_W-1:0]  ry;
        logic        [ANG_W-1:0]  expect_heading;
        logic        [ANG_W-1:0]  place_heading;
    } t_side;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_heading;
        logic signed [TRIG_W-1:0] sin_heading;
    } t_trig;

    typedef struct packed {
        logic signed [POS_W-1:0]  expect_x;
        logic signed [POS_W-1:0]  expect_y;
        logic        [ANG_W-1:0]  expect_heading;
        logic signed [POS_W-1:0]  place_x;
        logic signed [POS_W-1:0]  place_y;
        logic        [ANG_W-1:0]  place_heading;
        logic signed [TRIG_W-1:0] cos_heading;
        logic signed [TRIG_W-1:0] sin_heading;
    } t_obs_word;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/lpom_in_if.sv @@
// ----------------------------------------------------------------------------
// lpom_in_if
// Pose channel: robot pose, landmark pose and observed relative pose.
// ----------------------------------------------------------------------------
interface lpom_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lpom_pkg::POS_W-1:0]    robot_x;
    logic signed [lpom_pkg::POS_W-1:0]    robot_y;
    logic        [lpom_pkg::ANG_W-1:0]    robot_heading;
    logic signed [lpom_pkg::POS_W-1:0]    mark_x;
    logic signed [lpom_pkg::POS_W-1:0]    mark_y;
    logic        [lpom_pkg::ANG_W-1:0]    mark_heading;
    logic signed [lpom_pkg::POS_W-1:0]    seen_x;
    logic signed [lpom_pkg::POS_W-1:0]    seen_y;
    logic        [lpom_pkg::ANG_W-1:0]    seen_heading;

    modport source (
        output valid, robot_x, robot_y, robot_heading, mark_x, mark_y, mark_heading,
               seen_x, seen_y, seen_heading,
        input  ready
    );
    modport sink (
        input  valid, robot_x, robot_y, robot_heading, mark_x, mark_y, mark_heading,
               seen_x, seen_y, seen_heading,
        output ready
    );
endinterface

@@ rtl/core/lpom_out_if.sv @@
// ----------------------------------------------------------------------------
// lpom_out_if
// Observation channel: predicted observation, estimated landmark, cos and sin.
// ----------------------------------------------------------------------------
interface lpom_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lpom_pkg::POS_W-1:0]    expect_x;
    logic signed [lpom_pkg::POS_W-1:0]    expect_y;
    logic        [lpom_pkg::ANG_W-1:0]    expect_heading;
    logic signed [lpom_pkg::POS_W-1:0]    place_x;
    logic signed [lpom_pkg::POS_W-1:0]    place_y;
    logic        [lpom_pkg::ANG_W-1:0]    place_heading;
    logic signed [lpom_pkg::TRIG_W-1:0]   cos_heading;
    logic signed [lpom_pkg::TRIG_W-1:0]   sin_heading;

    modport source (
        output valid, expect_x, expect_y, expect_heading, place_x, place_y, place_heading,
               cos_heading, sin_heading,
        input  ready
    );
    modport sink (
        input  valid, expect_x, expect_y, expect_heading, place_x, place_y, place_heading,
               cos_heading, sin_heading,
        output ready
    );
endinterface

@@ rtl/core/landmark_pose_observation_model.sv @@
// ----------------------------------------------------------------------------
// landmark_pose_observation_model
// Planar rigid-transform observation model: predicted observation, landmark
// estimated from the observation, and cos and sin of the robot yaw.
// ----------------------------------------------------------------------------
//  port     dir  word
//  i_pose   in   robot, landmark and observed pose (x, y, heading each)
//  o_obs    out  expect xy/heading, place xy/heading, cos, sin
//
//  One word per cycle sustained while the output is not stalled. Stages in order:
//  fold, one CORDIC rotation per stage, trig rounding, products, sums,
//  rounding and saturation, output register.
//  Reset clears all valid bits synchronously; no word is taken during reset.
//  A stalled output parks one word in a skid register; the whole pipeline
//  then holds until that word moves on.
// ----------------------------------------------------------------------------
module landmark_pose_observation_model (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpom_in_if.sink     i_pose,
    lpom_out_if.source  o_obs
);

    lpom_pkg::t_pose_word w_in;
    lpom_pkg::t_trig      w_trig;
    lpom_pkg::t_side      w_side;
    lpom_pkg::t_obs_word  w_xf_word;
    lpom_pkg::t_obs_word  w_out_word;
    logic                 w_en;
    logic                 w_cordic_v;
    logic                 w_xf_v;

    assign w_in.robot_x       = i_pose.robot_x;
    assign w_in.robot_y       = i_pose.robot_y;
    assign w_in.robot_heading = i_pose.robot_heading;
    assign w_in.mark_x        = i_pose.mark_x;
    assign w_in.mark_y        = i_pose.mark_y;
    assign w_in.mark_heading  = i_pose.mark_heading;
    assign w_in.seen_x        = i_pose.seen_x;
    assign w_in.seen_y        = i_pose.seen_y;
    assign w_in.seen_heading  = i_pose.seen_heading;

    assign i_pose.ready = w_en && i_rst_n;

    lpom_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_pose.valid && i_pose.ready),
        .i_word  (w_in),
        .o_valid (w_cordic_v),
        .o_trig  (w_trig),
        .o_side  (w_side)
    );

    lpom_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cordic_v),
        .i_trig  (w_trig),
        .i_side  (w_side),
        .o_valid (w_xf_v),
        .o_word  (w_xf_word)
    );

    lpom_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_xf_v && w_en),
        .i_word  (w_xf_word),
        .i_ready (o_obs.ready),
        .o_en    (w_en),
        .o_valid (o_obs.valid),
        .o_word  (w_out_word)
    );

    assign o_obs.expect_x       = w_out_word.expect_x;
    assign o_obs.expect_y       = w_out_word.expect_y;
    assign o_obs.expect_heading = w_out_word.expect_heading;
    assign o_obs.place_x        = w_out_word.place_x;
    assign o_obs.place_y        = w_out_word.place_y;
    assign o_obs.place_heading  = w_out_word.place_heading;
    assign o_obs.cos_heading    = w_out_word.cos_heading;
    assign o_obs.sin_heading    = w_out_word.sin_heading;

endmodule

@@ rtl/core/lpom_cordic.sv @@
// ----------------------------------------------------------------------------
// lpom_cordic
// Pipelined CORDIC for cos and sin of the robot yaw, one rotation per stage,
// with the pose differences and the heading sum and difference carried alongside.
// ----------------------------------------------------------------------------
module lpom_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  lpom_pkg::t_pose_word  i_word,
    output logic                  o_valid,
    output lpom_pkg::t_trig       o_trig,
    output lpom_pkg::t_side       o_side
);

    localparam int N = lpom_pkg::STEPS_USED;

    logic signed [lpom_pkg::XY_W-1:0] r_x [0:N];
    logic signed [lpom_pkg::XY_W-1:0] r_y [0:N];
    logic signed [lpom_pkg::Z_W-1:0]  r_z [0:N];
    logic                             r_flip [0:N];
    lpom_pkg::t_side                  r_side [0:N];
    logic [N:0]                       r_v;

    logic                             r_out_v;
    lpom_pkg::t_trig                  r_trig;
    lpom_pkg::t_side                  r_side_out;

    logic signed [16:0]               n_a;
    logic                             n_flip;
    lpom_pkg::t_side                  n_side;
    logic signed [lpom_pkg::XY_W-1:0] n_xf;
    logic signed [lpom_pkg::XY_W-1:0] n_yf;

    function automatic logic signed [lpom_pkg::TRIG_W-1:0] to_trig(
        input logic signed [lpom_pkg::XY_W-1:0] v
    );
        logic signed [lpom_pkg::XY_W-1:0] r;
        r = (v + lpom_pkg::XY_W'(32768)) >>> 16;
        if (r > lpom_pkg::XY_W'(16384)) begin
            r = lpom_pkg::XY_W'(16384);
        end else if (r < -lpom_pkg::XY_W'(16384)) begin
            r = -lpom_pkg::XY_W'(16384);
        end
        return r[lpom_pkg::TRIG_W-1:0];
    endfunction

    always_comb begin
        n_a    = {i_word.robot_heading[lpom_pkg::ANG_W-1], i_word.robot_heading};
        n_flip = 1'b0;
        if (n_a > lpom_pkg::QUARTER) begin
            n_a    = n_a - lpom_pkg::HALF;
            n_flip = 1'b1;
        end else if (n_a < -lpom_pkg::QUARTER) begin
            n_a    = n_a + lpom_pkg::HALF;
            n_flip = 1'b1;
        end
        n_side.dx = lpom_pkg::DIFF_W'(i_word.mark_x) - lpom_pkg::DIFF_W'(i_word.robot_x);
        n_side.dy = lpom_pkg::DIFF_W'(i_word.mark_y) - lpom_pkg::DIFF_W'(i_word.robot_y);
        n_side.sx = i_word.seen_x;
        n_side.sy = i_word.seen_y;
        n_side.rx = i_word.robot_x;
        n_side.ry = i_word.robot_y;
        n_side.expect_heading = i_word.mark_heading - i_word.robot_heading;
        n_side.place_heading  = i_word.seen_heading + i_word.robot_heading;
        n_xf = r_flip[N] ? -r_x[N] : r_x[N];
        n_yf = r_flip[N] ? -r_y[N] : r_y[N];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= lpom_pkg::CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= {n_a, 16'b0};
            r_flip[0] <= n_flip;
            r_side[0] <= n_side;
            for (int k = 0; k < N; k++) begin
                if (!r_z[k][lpom_pkg::Z_W-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - $signed({1'b0, lpom_pkg::atan_turn(k)});
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + $signed({1'b0, lpom_pkg::atan_turn(k)});
                end
                r_flip[k+1] <= r_flip[k];
                r_side[k+1] <= r_side[k];
            end
            r_trig.cos_heading <= to_trig(n_xf);
            r_trig.sin_heading <= to_trig(n_yf);
            r_side_out         <= r_side[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[N-1:0], i_valid};
            r_out_v <= r_v[N];
        end
    end

    assign o_valid = r_out_v;
    assign o_trig  = r_trig;
    assign o_side  = r_side_out;

endmodule

@@ rtl/core/lpom_xform.sv @@
// ----------------------------------------------------------------------------
// lpom_xform
// Rigid-transform stages: products with cos and sin, sums, then rounding and
// saturation back to Q16.16.
// ----------------------------------------------------------------------------
module lpom_xform (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  lpom_pkg::t_trig       i_trig,
    input  lpom_pkg::t_side       i_side,
    output logic                  o_valid,
    output lpom_pkg::t_obs_word   o_word
);

    typedef struct packed {
        logic        [lpom_pkg::ANG_W-1:0] expect_heading;
        logic        [lpom_pkg::ANG_W-1:0] place_heading;
        lpom_pkg::t_trig                   trig;
    } t_pass;

    logic signed [lpom_pkg::PROD_W-1:0] r_dxc, r_dys, r_dyc, r_dxs;
    logic signed [lpom_pkg::PROD_W-1:0] r_sxc, r_sys, r_sxs, r_syc;
    logic signed [lpom_pkg::POS_W-1:0]  r_rx, r_ry;
    logic signed [lpom_pkg::SUM_W-1:0]  r_ex, r_ey, r_px, r_py;
    t_pass                              r_pass_p, r_pass_s;
    lpom_pkg::t_obs_word                r_word;
    logic [2:0]                         r_v;

    function automatic logic signed [lpom_pkg::POS_W-1:0] round_sat(
        input logic signed [lpom_pkg::SUM_W-1:0] v
    );
        logic signed [lpom_pkg::SUM_W-1:0] q;
        q = (v + lpom_pkg::SUM_W'(1 << (lpom_pkg::TRIG_FRAC - 1))) >>> lpom_pkg::TRIG_FRAC;
        if (q > lpom_pkg::SUM_W'(32'sh7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end else if (q < -lpom_pkg::SUM_W'(33'sh080000000)) begin
            return 32'sh80000000;
        end
        return q[lpom_pkg::POS_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dxc <= i_side.dx * i_trig.cos_heading;
            r_dys <= i_side.dy * i_trig.sin_heading;
            r_dyc <= i_side.dy * i_trig.cos_heading;
            r_dxs <= i_side.dx * i_trig.sin_heading;
            r_sxc <= i_side.sx * i_trig.cos_heading;
            r_sys <= i_side.sy * i_trig.sin_heading;
            r_sxs <= i_side.sx * i_trig.sin_heading;
            r_syc <= i_side.sy * i_trig.cos_heading;
            r_rx  <= i_side.rx;
            r_ry  <= i_side.ry;
            r_pass_p <= '{i_side.expect_heading, i_side.place_heading, i_trig};

            r_ex <= lpom_pkg::SUM_W'(r_dxc) + lpom_pkg::SUM_W'(r_dys);
            r_ey <= lpom_pkg::SUM_W'(r_dyc) - lpom_pkg::SUM_W'(r_dxs);
            r_px <= lpom_pkg::SUM_W'(r_sxc) - lpom_pkg::SUM_W'(r_sys)
                  + (lpom_pkg::SUM_W'(r_rx) <<< lpom_pkg::TRIG_FRAC);
            r_py <= lpom_pkg::SUM_W'(r_sxs) + lpom_pkg::SUM_W'(r_syc)
                  + (lpom_pkg::SUM_W'(r_ry) <<< lpom_pkg::TRIG_FRAC);
            r_pass_s <= r_pass_p;

            r_word.expect_x       <= round_sat(r_ex);
            r_word.expect_y       <= round_sat(r_ey);
            r_word.expect_heading <= r_pass_s.expect_heading;
            r_word.place_x        <= round_sat(r_px);
            r_word.place_y        <= round_sat(r_py);
            r_word.place_heading  <= r_pass_s.place_heading;
            r_word.cos_heading    <= r_pass_s.trig.cos_heading;
            r_word.sin_heading    <= r_pass_s.trig.sin_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid = r_v[2];
    assign o_word  = r_word;

endmodule

@@ rtl/core/lpom_outbuf.sv @@
// ----------------------------------------------------------------------------
// lpom_outbuf
// Output register with a skid word; the pipeline advances while the skid
// word is free.
// ----------------------------------------------------------------------------
module lpom_outbuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  lpom_pkg::t_obs_word   i_word,
    input  logic                  i_ready,
    output logic                  o_en,
    output logic                  o_valid,
    output lpom_pkg::t_obs_word   o_word
);

    logic                 r_out_v;
    logic                 r_skid_v;
    lpom_pkg::t_obs_word  r_out;
    lpom_pkg::t_obs_word  r_skid;
    logic                 n_free;

    assign n_free = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (n_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_free) begin
            r_out <= r_skid_v ? r_skid : i_word;
        end else if (i_valid) begin
            r_skid <= i_word;
        end
    end

    assign o_en    = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_word  = r_out;

endmodule

@@ rtl/core/lpom_checker.sv @@
// ----------------------------------------------------------------------------
// lpom_checker
// Port-level checks for the landmark pose observation model.
// ----------------------------------------------------------------------------
module lpom_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_ready,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [lpom_pkg::POS_W-1:0] i_expect_x,
    input  logic signed [lpom_pkg::POS_W-1:0] i_place_x,
    input  logic signed [lpom_pkg::TRIG_W-1:0] i_cos,
    input  logic signed [lpom_pkg::TRIG_W-1:0] i_sin
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_expect_x) && $stable(i_place_x) && $stable(i_cos) && $stable(i_sin))
        else $error("stalled output word changed");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !i_in_ready |-> $past(i_out_valid && !i_out_ready))
        else $error("input stalled without an output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind landmark_pose_observation_model lpom_checker u_lpom_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pose.ready),
    .i_out_valid (o_obs.valid),
    .i_out_ready (o_obs.ready),
    .i_expect_x  (o_obs.expect_x),
    .i_place_x   (o_obs.place_x),
    .i_cos       (o_obs.cos_heading),
    .i_sin       (o_obs.sin_heading)
);

@@ tb/lpom_obs_checker.sv @@
// ----------------------------------------------------------------------------
// lpom_obs_checker
// Watches the pose and observation channels, predicts each observation word
// from the accepted pose word with a bit-exact CORDIC and fixed-point
// transform, and compares every delivered word field by field in order.
// ----------------------------------------------------------------------------
module lpom_obs_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lpom_in_if   i_pose,
    lpom_out_if  i_obs,
    output int   o_fail_count,
    output int   o_pending
);

    localparam longint GAIN_Q30 = 652032874;
    localparam longint ATAN_TURN [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    lpom_pkg::t_obs_word obs_expected_q [$];
    int                  fails      = 0;
    int                  mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint round_trig(input longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    function automatic longint round_pos(input longint v);
        longint r;
        r = (v + 64'sd8192) >>> lpom_pkg::TRIG_FRAC;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic lpom_pkg::t_obs_word predict_observation(input lpom_pkg::t_pose_word p);
        lpom_pkg::t_obs_word res;
        longint    ang, x, y, z, xs, ys, c, s, dx, dy, rx, ry, sx, sy;
        bit        flip;
        ang  = longint'($signed(p.robot_heading));
        flip = 1'b0;
        if (ang > 16384) begin
            ang  = ang - 32768;
            flip = 1'b1;
        end else if (ang < -16384) begin
            ang  = ang + 32768;
            flip = 1'b1;
        end
        z = ang * 65536;
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < lpom_pkg::STEPS_USED; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURN[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURN[i];
            end
        end
        c  = round_trig(flip ? -x : x);
        s  = round_trig(flip ? -y : y);
        rx = longint'($signed(p.robot_x));
        ry = longint'($signed(p.robot_y));
        sx = longint'($signed(p.seen_x));
        sy = longint'($signed(p.seen_y));
        dx = longint'($signed(p.mark_x)) - rx;
        dy = longint'($signed(p.mark_y)) - ry;
        res.expect_x       = 32'(round_pos(dx * c + dy * s));
        res.expect_y       = 32'(round_pos(dy * c - dx * s));
        res.expect_heading = p.mark_heading - p.robot_heading;
        res.place_x        = 32'(round_pos(sx * c - sy * s + rx * 16384));
        res.place_y        = 32'(round_pos(sx * s + sy * c + ry * 16384));
        res.place_heading  = p.seen_heading + p.robot_heading;
        res.cos_heading    = 16'(c);
        res.sin_heading    = 16'(s);
        return res;
    endfunction

    task automatic check_field(input string tag, input longint want, input longint got);
        if (want != got) begin
            fails++;
            if (mismatches < 10)
                $display("mismatch %s: expected %0d, got %0d", tag, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        lpom_pkg::t_pose_word pw;
        lpom_pkg::t_obs_word  want;
        if (i_rst_n) begin
            if (i_obs.valid && i_obs.ready) begin
                if (obs_expected_q.size() == 0) begin
                    fails++;
                    if (mismatches < 10)
                        $display("unexpected observation word, expect_x %0d", i_obs.expect_x);
                    mismatches++;
                end else begin
                    want = obs_expected_q.pop_front();
                    check_field("expect_x", want.expect_x, i_obs.expect_x);
                    check_field("expect_y", want.expect_y, i_obs.expect_y);
                    check_field("expect_heading", want.expect_heading, i_obs.expect_heading);
                    check_field("place_x", want.place_x, i_obs.place_x);
                    check_field("place_y", want.place_y, i_obs.place_y);
                    check_field("place_heading", want.place_heading, i_obs.place_heading);
                    check_field("cos_heading", want.cos_heading, i_obs.cos_heading);
                    check_field("sin_heading", want.sin_heading, i_obs.sin_heading);
                end
            end
            if (i_pose.valid && i_pose.ready) begin
                pw.robot_x       = i_pose.robot_x;
                pw.robot_y       = i_pose.robot_y;
                pw.robot_heading = i_pose.robot_heading;
                pw.mark_x        = i_pose.mark_x;
                pw.mark_y        = i_pose.mark_y;
                pw.mark_heading  = i_pose.mark_heading;
                pw.seen_x        = i_pose.seen_x;
                pw.seen_y        = i_pose.seen_y;
                pw.seen_heading  = i_pose.seen_heading;
                obs_expected_q.push_back(predict_observation(pw));
            end
        end
        o_fail_count <= fails;
        o_pending    <= obs_expected_q.size();
    end

endmodule

@@ tb/landmark_pose_observation_model_tb.sv @@
// ----------------------------------------------------------------------------
// landmark_pose_observation_model_tb
// Drives directed and random pose words into the observation model with
// random idling on both channels and one long output stall, and reports the
// verdict from the checker's failure count and backlog.
// ----------------------------------------------------------------------------
module landmark_pose_observation_model_tb;

    localparam int RANDOM_WORDS = 1300;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = lpom_pkg::STEPS_USED + 16;
    localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh80000000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    int   send_mode   = 0;
    int   recv_mode   = 0;
    int   sent        = 0;
    int   taken       = 0;

    always #5 i_clk = ~i_clk;

    lpom_in_if  pose_if ();
    lpom_out_if obs_if ();

    landmark_pose_observation_model dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pose  (pose_if),
        .o_obs   (obs_if)
    );

    lpom_obs_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pose       (pose_if),
        .i_obs        (obs_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if ((pose_if.valid && pose_if.ready) || (obs_if.valid && obs_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[landmark_pose_observation_model] ERROR");
            $finish;
        end
    end

    function automatic lpom_pkg::t_pose_word make_pose(
        input logic [31:0] rx, input logic [31:0] ry, input logic [15:0] rh,
        input logic [31:0] mx, input logic [31:0] my, input logic [15:0] mh,
        input logic [31:0] sx, input logic [31:0] sy, input logic [15:0] sh
    );
        lpom_pkg::t_pose_word w;
        w.robot_x = rx;  w.robot_y = ry;  w.robot_heading = rh;
        w.mark_x  = mx;  w.mark_y  = my;  w.mark_heading  = mh;
        w.seen_x  = sx;  w.seen_y  = sy;  w.seen_heading  = sh;
        return w;
    endfunction

    function automatic logic [31:0] rand_pos();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = POS_MAX;
                    1: v = POS_MIN;
                    2: v = 32'h0;
                    default: v = 32'hFFFFFFFF;
                endcase
            end
            1, 2, 3, 4: v = $urandom;
            default: v = 32'($urandom_range(0, 32'h00FFFFFF)) - 32'h00800000;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_heading();
        logic [15:0] v;
        if ($urandom_range(0, 4) == 0)
            v = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 4)) - 16'd2;
        else
            v = 16'($urandom_range(0, 65535));
        return v;
    endfunction

    task automatic send_pose(input lpom_pkg::t_pose_word w);
        int gap;
        if (sent % 50 == 0)
            send_mode = $urandom_range(0, 3);
        gap = (send_mode == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            pose_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pose_if.robot_x       <= w.robot_x;
        pose_if.robot_y       <= w.robot_y;
        pose_if.robot_heading <= w.robot_heading;
        pose_if.mark_x        <= w.mark_x;
        pose_if.mark_y        <= w.mark_y;
        pose_if.mark_heading  <= w.mark_heading;
        pose_if.seen_x        <= w.seen_x;
        pose_if.seen_y        <= w.seen_y;
        pose_if.seen_heading  <= w.seen_heading;
        pose_if.valid         <= 1'b1;
        do @(posedge i_clk); while (!pose_if.ready);
        sent++;
    endtask

    initial begin : stimulus
        i_rst_n               <= 1'b0;
        pose_if.valid         <= 1'b0;
        pose_if.robot_x       <= '0;
        pose_if.robot_y       <= '0;
        pose_if.robot_heading <= '0;
        pose_if.mark_x        <= '0;
        pose_if.mark_y        <= '0;
        pose_if.mark_heading  <= '0;
        pose_if.seen_x        <= '0;
        pose_if.seen_y        <= '0;
        pose_if.seen_heading  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pose(make_pose(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pose(make_pose(32'h10000, 0, 16384, 32'h50000, 32'h30000, 100,
                            32'h20000, 32'h8000, 200));
        send_pose(make_pose(32'h10000, 0, 32768, 32'h50000, 32'h30000, 100,
                            32'h20000, 32'h8000, 200));
        send_pose(make_pose(32'h10000, 0, 49152, 32'h50000, 32'h30000, 100,
                            32'h20000, 32'h8000, 200));
        send_pose(make_pose(32'h10000, 0, 16385, 32'h50000, 32'h30000, 100,
                            32'h20000, 32'h8000, 200));
        send_pose(make_pose(32'h10000, 0, 49151, 32'h50000, 32'h30000, 100,
                            32'h20000, 32'h8000, 200));
        send_pose(make_pose(32'h10000, 0, 65535, 32'h50000, 32'h30000, 100,
                            32'h20000, 32'h8000, 200));
        send_pose(make_pose(32'h10000, 0, 8192, 32'h50000, 32'h30000, 100,
                            32'h20000, 32'h8000, 200));
        // saturate the predicted and estimated positions
        send_pose(make_pose(POS_MIN, 0, 0, POS_MAX, 0, 0, 0, 0, 0));
        send_pose(make_pose(POS_MAX, 0, 0, POS_MIN, 0, 0, 0, 0, 0));
        send_pose(make_pose(0, POS_MIN, 0, 0, POS_MAX, 0, 0, 0, 0));
        send_pose(make_pose(POS_MAX, 0, 0, 0, 0, 0, POS_MAX, 0, 0));
        send_pose(make_pose(0, POS_MIN, 0, 0, 0, 0, 0, POS_MIN, 0));
        // wrap the heading sum and difference
        send_pose(make_pose(0, 0, 1, 0, 0, 0, 0, 0, 65535));
        send_pose(make_pose(POS_MAX, POS_MAX, 65535, POS_MAX, POS_MAX, 65535,
                            POS_MAX, POS_MAX, 65535));
        send_pose(make_pose(POS_MIN, POS_MIN, 32768, POS_MIN, POS_MIN, 32768,
                            POS_MIN, POS_MIN, 32768));
        send_pose(make_pose(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF,
                            32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                            16'hFFFF));
        send_pose(make_pose(0, 0, 16384, POS_MAX, POS_MIN, 0, POS_MIN, POS_MAX, 0));
        send_pose(make_pose(POS_MIN, POS_MAX, 49152, POS_MAX, POS_MIN, 16384,
                            POS_MAX, POS_MIN, 49152));

        for (int n = 0; n < RANDOM_WORDS; n++)
            send_pose(make_pose(rand_pos(), rand_pos(), rand_heading(),
                                rand_pos(), rand_pos(), rand_heading(),
                                rand_pos(), rand_pos(), rand_heading()));
        pose_if.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[landmark_pose_observation_model] OK");
        else
            $display("[landmark_pose_observation_model] ERROR");
        $finish;
    end

    initial begin : receiver
        int gap;
        forever begin
            if (taken == HOLD_AT) begin
                obs_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (taken % 50 == 0)
                recv_mode = $urandom_range(0, 3);
            gap = (recv_mode == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                obs_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            obs_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(obs_if.valid && i_rst_n));
            taken++;
        end
    end

endmodule
